// File: rtl/core/nksl_pkg.sv
package nksl_pkg;

  localparam int unsigned KeyW         = 24;
  localparam int unsigned PayW         = 32;
  localparam int unsigned RankW        = 4;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [StatusW-1:0] {
    StInserted = 3'd0,
    StEvicted  = 3'd1,
    StRejected = 3'd2,
    StEntry    = 3'd3,
    StEmpty    = 3'd4
  } status_e;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdDrain  = 1'b1
  } cmd_e;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new request, shifting farther entries up
    logic shift;   // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

// File: rtl/core/nksl_cell.sv
module nksl_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nksl_pkg::cell_ctrl_t        ctrl_i,
  input  logic [nksl_pkg::KeyW-1:0]   new_key_i,
  input  logic [nksl_pkg::PayW-1:0]   new_payload_i,
  input  logic                        prev_valid_i,
  input  logic                        prev_gt_i,
  input  logic [nksl_pkg::KeyW-1:0]   prev_key_i,
  input  logic [nksl_pkg::PayW-1:0]   prev_payload_i,
  input  logic                        next_valid_i,
  input  logic [nksl_pkg::KeyW-1:0]   next_key_i,
  input  logic [nksl_pkg::PayW-1:0]   next_payload_i,
  output logic                        valid_o,
  output logic                        gt_o,
  output logic [nksl_pkg::KeyW-1:0]   key_o,
  output logic [nksl_pkg::PayW-1:0]   payload_o
);

  logic                      valid_q, valid_d;
  logic [nksl_pkg::KeyW-1:0] key_q, key_d;
  logic [nksl_pkg::PayW-1:0] payload_q, payload_d;
  logic                      gt;
  logic                      take_new;

  // Strictly greater keeps equal keys ahead of the new request.
  assign gt = valid_q && (key_q > new_key_i);
  assign take_new = gt || (!valid_q && prev_valid_i);

  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.shift) begin
      valid_d   = next_valid_i;
      key_d     = next_key_i;
      payload_d = next_payload_i;
    end else if (ctrl_i.insert) begin
      if (prev_gt_i) begin
        valid_d   = prev_valid_i;
        key_d     = prev_key_i;
        payload_d = prev_payload_i;
      end else if (take_new) begin
        valid_d   = 1'b1;
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign gt_o      = gt;
  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

// File: rtl/core/nearest_k_sorted_request_list_unit.sv
// Insert: one transaction per cycle when not stalled, result in the next cycle.
// Drain: n entries stream out one per cycle from the head cell of the chain, input
// held off until the last entry has been handed to the output register.
// An empty drain gives one result in the next cycle. Output stalls hold the chain.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result.
module nearest_k_sorted_request_list_unit #(
  parameter int unsigned DEPTH = nksl_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // distance_key [23:0], payload [55:24]
  input  logic [0:0]  s_axis_tuser,   // command [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_key [23:0], out_payload [55:24], rank [59:56]
  output logic [2:0]  m_axis_tuser,   // status [2:0]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned CntW = $clog2(DEPTH);

  logic [nksl_pkg::KeyW-1:0] new_key;
  logic [nksl_pkg::PayW-1:0] new_payload;
  nksl_pkg::cmd_e            cmd;

  logic [DEPTH-1:0]          valid;
  logic [DEPTH-1:0]          gt;
  logic [nksl_pkg::KeyW-1:0] key   [DEPTH];
  logic [nksl_pkg::PayW-1:0] payld [DEPTH];

  nksl_pkg::cell_ctrl_t ctrl;

  logic                       out_valid_q;
  nksl_pkg::status_e          out_status_q;
  logic [nksl_pkg::KeyW-1:0]  out_key_q;
  logic [nksl_pkg::PayW-1:0]  out_payload_q;
  logic [nksl_pkg::RankW-1:0] out_rank_q;
  logic                       out_last_q;

  logic            drain_q;
  logic [CntW-1:0] drain_rank_q;

  logic            can_load;
  logic            acc, ins_acc, drn_acc;
  logic            full, reject;
  logic            drain_step;
  logic [CntW-1:0] pos;
  logic [CntW-1:0] emit_rank;
  logic [31:0]     pos_wide, emit_wide;

  assign new_key     = s_axis_tdata[23:0];
  assign new_payload = s_axis_tdata[55:24];
  assign cmd         = nksl_pkg::cmd_e'(s_axis_tuser[0]);

  assign can_load      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !drain_q && can_load;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign ins_acc       = acc && (cmd == nksl_pkg::CmdInsert);
  assign drn_acc       = acc && (cmd == nksl_pkg::CmdDrain);

  // A full list keeps its farthest entry unless the new key is strictly smaller.
  assign full       = valid[DEPTH-1];
  assign reject     = full && !gt[DEPTH-1];
  assign drain_step = (drn_acc && valid[0]) || (drain_q && can_load);

  assign ctrl.insert = ins_acc && !reject;
  assign ctrl.shift  = drain_step;

  // Occupied entries that stay ahead of the new request form a prefix of the chain.
  always_comb begin
    pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!(valid[i] && !gt[i])) begin
        pos = CntW'(i);
      end
    end
  end

  assign emit_rank = drn_acc ? '0 : drain_rank_q;
  assign pos_wide  = 32'(pos);
  assign emit_wide = 32'(emit_rank);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      prev_valid, prev_gt, next_valid;
    logic [nksl_pkg::KeyW-1:0] prev_key, next_key;
    logic [nksl_pkg::PayW-1:0] prev_payload, next_payload;

    if (i == 0) begin : g_head
      assign prev_valid   = 1'b1;
      assign prev_gt      = 1'b0;
      assign prev_key     = '0;
      assign prev_payload = '0;
    end else begin : g_body
      assign prev_valid   = valid[i-1];
      assign prev_gt      = gt[i-1];
      assign prev_key     = key[i-1];
      assign prev_payload = payld[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid   = 1'b0;
      assign next_key     = '0;
      assign next_payload = '0;
    end else begin : g_link
      assign next_valid   = valid[i+1];
      assign next_key     = key[i+1];
      assign next_payload = payld[i+1];
    end

    nksl_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_key_i      (new_key),
      .new_payload_i  (new_payload),
      .prev_valid_i   (prev_valid),
      .prev_gt_i      (prev_gt),
      .prev_key_i     (prev_key),
      .prev_payload_i (prev_payload),
      .next_valid_i   (next_valid),
      .next_key_i     (next_key),
      .next_payload_i (next_payload),
      .valid_o        (valid[i]),
      .gt_o           (gt[i]),
      .key_o          (key[i]),
      .payload_o      (payld[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      drain_q      <= 1'b0;
      drain_rank_q <= '0;
    end else begin
      if (acc || drain_step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (drain_step) begin
        // Cell one still holding an entry means more follow the head.
        drain_q      <= valid[1];
        drain_rank_q <= emit_rank + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_step) begin
      out_status_q  <= nksl_pkg::StEntry;
      out_key_q     <= key[0];
      out_payload_q <= payld[0];
      out_rank_q    <= emit_wide[nksl_pkg::RankW-1:0];
      out_last_q    <= !valid[1];
    end else if (drn_acc) begin
      out_status_q  <= nksl_pkg::StEmpty;
      out_key_q     <= '0;
      out_payload_q <= '0;
      out_rank_q    <= '0;
      out_last_q    <= 1'b1;
    end else if (ins_acc) begin
      out_key_q     <= '0;
      out_payload_q <= '0;
      out_last_q    <= 1'b1;
      if (reject) begin
        out_status_q <= nksl_pkg::StRejected;
        out_rank_q   <= '0;
      end else begin
        out_status_q <= full ? nksl_pkg::StEvicted : nksl_pkg::StInserted;
        out_rank_q   <= pos_wide[nksl_pkg::RankW-1:0];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_rank_q, out_payload_q, out_key_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule
